>>> src/drp_pkg.sv
// Shared types and constants for the double round-and-pack pipeline.
package drp_pkg;

    localparam int SIG_W      = 64;
    localparam int EXP_IN_W   = 13;
    localparam int EXP_W      = 14;
    localparam int MSB_W      = 6;
    localparam int AMT_W      = 7;
    localparam logic [MSB_W-1:0] HIDDEN_POS = 6'd55;
    localparam logic [AMT_W-1:0] SHIFT_ALL  = 7'd64;
    localparam logic [10:0]      EXP_MAX    = 11'h7FF;
    localparam logic signed [EXP_W-1:0] EXP_INF = 14'sd2047;

    typedef struct packed {
        logic                       sign;
        logic signed [EXP_IN_W-1:0] exp;
        logic [SIG_W-1:0]           sig;
    } drp_in_t;

    typedef struct packed {
        logic                       sign;
        logic                       zero;
        logic signed [EXP_IN_W-1:0] exp;
        logic [SIG_W-1:0]           sig;
        logic [MSB_W-1:0]           msb;
    } drp_lead_t;

    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic                    left;
        logic [AMT_W-1:0]        amt;
        logic signed [EXP_W-1:0] exp;
        logic [SIG_W-1:0]        sig;
    } drp_plan_t;

    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic signed [EXP_W-1:0] exp;
        logic [SIG_W-1:0]        sig;
    } drp_norm_t;

endpackage

>>> src/drp_lead.sv
// Stage 1: register the operand and locate the leading one of the significand.
module drp_lead import drp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  drp_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output drp_lead_t out_data
);
    logic      vld_reg;
    drp_lead_t data_reg, data_next;

    always_comb begin
        data_next.sign = in_data.sign;
        data_next.exp  = in_data.exp;
        data_next.sig  = in_data.sig;
        data_next.zero = (in_data.sig == '0);
        data_next.msb  = '0;
        for (int i = 0; i < SIG_W; i++) begin
            if (in_data.sig[i]) begin
                data_next.msb = MSB_W'(i);
            end
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

>>> src/drp_plan.sv
// Stage 2: pick shift direction, amount and adjusted exponent.
module drp_plan import drp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  drp_lead_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output drp_plan_t out_data
);
    logic      vld_reg;
    drp_plan_t data_reg, data_next;

    logic [3:0]              k;
    logic signed [EXP_W-1:0] e, ek, emax, nfull;
    logic [MSB_W-1:0]        lfull;

    always_comb begin
        e     = {in_data.exp[EXP_IN_W-1], in_data.exp};
        k     = (in_data.msb > HIDDEN_POS) ? 4'(in_data.msb - HIDDEN_POS) : 4'd0;
        ek    = e + $signed({10'd0, k});
        nfull = 14'sd1 - e;
        lfull = HIDDEN_POS - in_data.msb;
        emax  = e - 14'sd1;
        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.sig  = in_data.sig;
        if (ek < 14'sd1) begin
            // denormalize: sticky right shift up to exponent 1
            data_next.left = 1'b0;
            data_next.amt  = (nfull > 14'sd64) ? SHIFT_ALL : nfull[AMT_W-1:0];
            data_next.exp  = 14'sd1;
        end else if ((in_data.msb < HIDDEN_POS) && (e >= 14'sd2)) begin
            // normalize left, stop at exponent 1
            data_next.left = 1'b1;
            data_next.amt  = (emax < $signed({8'd0, lfull})) ? emax[AMT_W-1:0]
                                                             : {1'b0, lfull};
            data_next.exp  = e - $signed({7'd0, data_next.amt});
        end else begin
            data_next.left = 1'b0;
            data_next.amt  = {3'd0, k};
            data_next.exp  = ek;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

>>> src/drp_shift.sv
// Stage 3: barrel shift the significand, keeping sticky on right shifts.
module drp_shift import drp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  drp_plan_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output drp_norm_t out_data
);
    logic      vld_reg;
    drp_norm_t data_reg, data_next;
    logic [SIG_W-1:0] mask;
    logic             lost;

    always_comb begin
        mask = ~({SIG_W{1'b1}} << in_data.amt[MSB_W-1:0]);
        lost = |(in_data.sig & mask);
        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.exp  = in_data.exp;
        if (in_data.left) begin
            data_next.sig = in_data.sig << in_data.amt[MSB_W-1:0];
        end else if (in_data.amt >= SHIFT_ALL) begin
            data_next.sig = {{(SIG_W-1){1'b0}}, |in_data.sig};
        end else begin
            data_next.sig = (in_data.sig >> in_data.amt[MSB_W-1:0])
                          | {{(SIG_W-1){1'b0}}, lost};
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

>>> src/drp_round.sv
// Stage 4: round to nearest even, renormalize, pack into the output register.
module drp_round import drp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  drp_norm_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data
);
    logic        vld_reg;
    logic [63:0] data_reg, data_next;
    logic [SIG_W-1:0]        s;
    logic signed [EXP_W-1:0] e;
    logic [2:0]              g;
    logic                    up;

    always_comb begin
        g  = in_data.sig[2:0];
        up = (g > 3'd4) || ((g == 3'd4) && in_data.sig[3]);
        s  = in_data.sig + (up ? 64'd8 : 64'd0);
        e  = in_data.exp;
        if (s[56]) begin
            s = s >> 1;
            e = e + 14'sd1;
        end
        if (in_data.zero) begin
            data_next = {in_data.sign, 63'd0};
        end else if (!s[55]) begin
            data_next = {in_data.sign, 11'd0, s[54:3]};
        end else if (e >= EXP_INF) begin
            data_next = {in_data.sign, EXP_MAX, 52'd0};
        end else begin
            data_next = {in_data.sign, e[10:0], s[54:3]};
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

>>> src/double_round_and_pack.sv
// Usage:
// Converts a sign, a signed biased exponent and a working significand
// (hidden bit at 55, three guard bits) into a packed IEEE-754 double.
// Input channel s_*: one transaction per operand, accepted when
// s_tvalid and s_tready are both high at a rising edge of aclk.
// Output channel m_*: one transaction per operand, in order.
// Pipeline: four register stages (leading-one search, shift planning,
// barrel shift with sticky, round and pack). m_tvalid rises once the
// operand has passed every stage register; throughput is one
// transaction per cycle while the receiver keeps m_tready high.
// Each stage holds its own valid bit, so bubbles collapse: while the
// receiver stalls, upstream stages keep filling and s_tready drops only
// once all four stages hold data. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the datapath
// registers are not reset.
module double_round_and_pack import drp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] sign_bit, [13:1] biased_exponent, [77:14] significand, [79:78] zero
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] packed_double
    output logic [63:0] m_tdata
);
    drp_in_t   in_d;
    drp_lead_t lead_d;
    drp_plan_t plan_d;
    drp_norm_t norm_d;
    logic v1, r1, v2, r2, v3, r3;

    // Unpack the operand fields from the input transaction.
    assign in_d.sign = s_tdata[0];
    assign in_d.exp  = $signed(s_tdata[13:1]);
    assign in_d.sig  = s_tdata[77:14];

    drp_lead u_lead (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_d),
        .out_valid(v1), .out_ready(r1), .out_data(lead_d)
    );

    drp_plan u_plan (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v1), .in_ready(r1), .in_data(lead_d),
        .out_valid(v2), .out_ready(r2), .out_data(plan_d)
    );

    drp_shift u_shift (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v2), .in_ready(r2), .in_data(plan_d),
        .out_valid(v3), .out_ready(r3), .out_data(norm_d)
    );

    drp_round u_round (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(v3), .in_ready(r3), .in_data(norm_d),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

`ifndef ASSERT_OFF
    // Input backpressure only when the whole pipe is full and stalled.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1 && v2 && v3 && m_tvalid && !m_tready))
        else $error("s_tready low without a full stalled pipeline");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled shift-stage entry holds its value.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !r3) |=> (v3 && $stable(norm_d)))
        else $error("shift stage changed while stalled");
`endif
endmodule

>>> test/double_round_and_pack_checker.sv
// Checker for the double round-and-pack block: predicts each packed double and compares.
`timescale 1ns / 1ps

module double_round_and_pack_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    logic [63:0] expected_doubles[$];

    function automatic logic [63:0] shr_sticky(logic [63:0] v, int n);
        if (n <= 0) return v;
        if (n >= 64) return (v != 0) ? 64'd1 : 64'd0;
        return (v >> n) | (((v << (64 - n)) != 0) ? 64'd1 : 64'd0);
    endfunction

    function automatic logic [63:0] round_pack(logic sgn, logic signed [12:0] e13,
                                               logic [63:0] sig_in);
        int          ex;
        logic [63:0] sig;
        logic [2:0]  grd;
        ex  = int'(e13);
        sig = sig_in;
        if (sig == 0) return {sgn, 63'd0};
        while (sig >= 64'h0100_0000_0000_0000) begin
            sig = shr_sticky(sig, 1);
            ex++;
        end
        while (sig < 64'h0080_0000_0000_0000 && ex >= 2) begin
            sig = sig << 1;
            ex--;
        end
        if (ex < 1) begin
            sig = shr_sticky(sig, 1 - ex);
            ex  = 1;
        end
        grd = sig[2:0];
        if (grd > 3'd4 || (grd == 3'd4 && sig[3])) begin
            sig = sig + 64'd8;
            if (sig >= 64'h0100_0000_0000_0000) begin
                sig = shr_sticky(sig, 1);
                ex++;
            end
        end
        if (sig < 64'h0080_0000_0000_0000) ex = 0;
        else if (ex >= 2047) return {sgn, 11'h7FF, 52'd0};
        return {sgn, ex[10:0], sig[54:3]};
    endfunction

    assign pending_count = expected_doubles.size();

    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_doubles.push_back(round_pack(s_tdata[0], s_tdata[13:1], s_tdata[77:14]));
            if (m_tvalid && m_tready) begin
                if (expected_doubles.size() == 0) begin
                    $error("unexpected result transaction: packed_double %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_doubles.pop_front();
                    if (want !== m_tdata) begin
                        $error("packed_double mismatch: expected %h actual %h", want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb.sv
// Testbench top for the double round-and-pack block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
    import drp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [0] sign_bit, [13:1] biased_exponent, [77:14] significand, [79:78] zero
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [63:0] packed_double
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          quiet_cycles;
    bit          stim_done;

    localparam int QUIET_LIMIT = 2000;

    double_round_and_pack i_dut (.*);

    double_round_and_pack_checker i_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending_count
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Return a gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // After a random idle gap, send one transaction; hold it until the handshake completes.
    task automatic send_operand(logic sgn, logic [12:0] ex, logic [63:0] sig);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sig, ex, sgn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random significand: raw, zero, tie, near carry, normalized or a random leading one.
    function automatic logic [63:0] rand_sig();
        logic [63:0] raw;
        int          top;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return raw;
            1: return 64'd0;
            2: begin
                top = $urandom_range(0, 63);
                return (raw >> (63 - top)) | (64'd1 << top);
            end
            3: return {8'h00, 1'b1, raw[54:3], 3'b100};   // exact tie
            4: return {8'h00, 1'b1, {52{1'b1}}, raw[2:0]}; // near carry
            default: return {8'h00, 1'b1, raw[54:0]};      // already normalized
        endcase
    endfunction

    function automatic logic [12:0] rand_exp();
        case ($urandom_range(0, 7))
            0: return 13'($urandom);
            1: return 13'($urandom_range(0, 70)) - 13'd60;  // subnormal edge
            2: return 13'($urandom_range(2030, 2060));      // overflow edge
            default: return 13'($urandom_range(1, 2046));
        endcase
    endfunction

    // Receiver: stall in random stretches.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles without any transaction.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT && !stim_done) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int guard;
        stim_done = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zeros, extremes, ties, overflow, deep underflow, carry.
        send_operand(1'b0, 13'd0, 64'd0);
        send_operand(1'b1, 13'h0FFF, 64'd0);
        send_operand(1'b0, 13'd1023, 64'h0080_0000_0000_0000);
        send_operand(1'b1, 13'd1023, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(1'b0, 13'h1000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operand(1'b1, 13'h0FFF, 64'd1);
        send_operand(1'b0, 13'd2046, 64'h00FF_FFFF_FFFF_FFFF);
        send_operand(1'b0, 13'd2047, 64'h0080_0000_0000_0000);
        send_operand(1'b1, 13'd2046, 64'h0080_0000_0000_0000);
        send_operand(1'b0, 13'd1, 64'h0000_0000_0000_0008);
        send_operand(1'b0, 13'd0, 64'h00FF_FFFF_FFFF_FFFC);
        send_operand(1'b0, 13'd0, 64'h00FF_FFFF_FFFF_FFF8);
        send_operand(1'b1, 13'h1FC0, 64'h0080_0000_0000_0000);
        send_operand(1'b0, 13'h1FC9, 64'h00FF_0000_0000_0000);
        send_operand(1'b0, 13'd100, 64'h0080_0000_0000_000C);
        send_operand(1'b0, 13'd100, 64'h0080_0000_0000_0004);
        send_operand(1'b1, 13'd100, 64'h0080_0000_0000_0005);
        send_operand(1'b0, 13'd5, 64'h0000_0000_0000_0100);
        send_operand(1'b0, 13'd1, 64'h007F_FFFF_FFFF_FFFC);
        send_operand(1'b1, 13'd1500, 64'h8000_0000_0000_0001);

        repeat (1250) send_operand(1'($urandom_range(0, 1)), rand_exp(), rand_sig());
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        guard = 0;
        while (pending_count != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (pending_count == 0 && fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
